@@ src/tdpg_pkg.sv @@
// Shared constants for the trial division prime generator.
package tdpg_pkg;

  localparam int TargetBits   = 11;
  localparam int PrimeOutBits = 16;
  localparam int IndexOutBits = 10;

  localparam logic [TargetBits-1:0] TargetReset = 11'd1024;

  localparam int FirstCandidate = 2;

endpackage

@@ src/tdpg_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module tdpg_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/tdpg_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module tdpg_div #(
  parameter int Width = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quot_o,
  output logic [Width-1:0] rem_o
);

  localparam int CntBits = $clog2(Width + 1);

  logic [CntBits-1:0] cnt_q;
  logic [Width-1:0]   quot_q;
  logic [Width-1:0]   rem_q;
  logic [Width-1:0]   div_q;
  logic               done_q;
  logic [Width:0]     trial;
  logic               fits;

  assign trial = {rem_q, quot_q[Width-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      quot_q <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CntBits'(Width);
        quot_q <= dividend_i;
        rem_q  <= '0;
        div_q  <= divisor_i;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntBits'(1);
        if (fits) begin
          rem_q <= Width'(trial - {1'b0, div_q});
        end else begin
          rem_q <= trial[Width-1:0];
        end
        quot_q <= {quot_q[Width-2:0], fits};
        if (cnt_q == CntBits'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

`ifndef NO_ASSERTIONS
  a_done_after_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> cnt_q == '0)
    else $error("divider done while steps remain");
  a_step_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!start_i && cnt_q != '0) |=> cnt_q == $past(cnt_q) - CntBits'(1))
    else $error("divider step count skipped");
  a_remainder_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rem_o < div_q)
    else $error("divider remainder not reduced");
`endif

endmodule

@@ src/trial_division_prime_generator_top.sv @@
// Top level of the trial division prime generator.
// Each transaction accepted on start (while busy is low) yields one result strobe on valid_o:
// the next prime in ascending order from 2 with its zero-based index, or done_res_o with zero
// value once cfg_target_count_i primes (at most MAX_PRIMES) have been produced or no further
// prime fits in VALUE_BITS bits. restart_i starts the sequence again from 2. A done result
// for a reached target comes in the cycle after acceptance. Otherwise each candidate takes
// the ST_NEXT step, then for each stored prime tried a check, a table read and a division in
// the restoring divider, plus one more check when every stored prime has been tried. The
// divider returns quotient and remainder together: the trial stops when the prime exceeds
// the quotient or divides evenly. The result strobe follows the last of these steps.
// Results are not held: the receiver takes each one in its single strobe cycle.
module trial_division_prime_generator_top
  import tdpg_pkg::*;
#(
  parameter int MAX_PRIMES = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [TargetBits-1:0]   cfg_target_count_i,
  input  logic                    start,
  input  logic                    restart_i,
  output logic                    busy,
  output logic                    valid_o,
  output logic [PrimeOutBits-1:0] prime_value_o,
  output logic [IndexOutBits-1:0] prime_index_o,
  output logic                    done_res_o
);

  localparam int AddrBits = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int CntBits  = $clog2(MAX_PRIMES + 1);
  localparam int CmpBits  = (CntBits > TargetBits) ? CntBits : TargetBits;
  localparam logic [CmpBits-1:0] MaxPrimesC = CmpBits'(MAX_PRIMES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_CHECK,
    ST_LOAD,
    ST_DIV
  } state_e;

  state_e                state_q;
  logic [TargetBits-1:0] target_q;
  logic [CntBits-1:0]    count_q;
  logic [CntBits-1:0]    idx_q;
  logic [VALUE_BITS:0]   cand_q;
  logic [VALUE_BITS-1:0] c_q;
  logic [VALUE_BITS-1:0] p_q;

  logic [CmpBits-1:0]    target_ext;
  logic [CmpBits-1:0]    limit;
  logic [CntBits-1:0]    eff_count;
  logic                  reached;
  logic                  found;
  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [VALUE_BITS-1:0] div_rem;
  logic [VALUE_BITS-1:0] ram_rdata;
  logic [31:0]           c_ext;
  logic [31:0]           count_ext;

  assign target_ext = CmpBits'(target_q);
  assign limit      = (target_ext > MaxPrimesC) ? MaxPrimesC : target_ext;
  assign eff_count  = restart_i ? '0 : count_q;
  assign reached    = CmpBits'(eff_count) >= limit;
  assign c_ext      = 32'(c_q);
  assign count_ext  = 32'(count_q);

  always_comb begin
    found     = 1'b0;
    div_start = 1'b0;
    case (state_q)
      ST_CHECK: found = idx_q >= count_q;
      ST_LOAD: begin
        found     = ram_rdata == '0;
        div_start = ram_rdata != '0;
      end
      ST_DIV:  found = div_done && (p_q > div_quot);
      default: found = 1'b0;
    endcase
  end

  tdpg_ram #(
    .Width(VALUE_BITS),
    .Depth(MAX_PRIMES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (found),
    .waddr_i(count_q[AddrBits-1:0]),
    .wdata_i(c_q),
    .raddr_i(idx_q[AddrBits-1:0]),
    .rdata_o(ram_rdata)
  );

  tdpg_div #(
    .Width(VALUE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(c_q),
    .divisor_i (ram_rdata),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      target_q      <= TargetReset;
      count_q       <= '0;
      idx_q         <= '0;
      cand_q        <= (VALUE_BITS + 1)'(FirstCandidate);
      c_q           <= '0;
      p_q           <= '0;
      valid_o       <= 1'b0;
      prime_value_o <= '0;
      prime_index_o <= '0;
      done_res_o    <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      if (cfg_we_i) begin
        target_q <= cfg_target_count_i;
      end
      if (found) begin
        valid_o       <= 1'b1;
        prime_value_o <= c_ext[PrimeOutBits-1:0];
        prime_index_o <= count_ext[IndexOutBits-1:0];
        done_res_o    <= 1'b0;
        count_q       <= count_q + CntBits'(1);
        state_q       <= ST_IDLE;
      end else begin
        case (state_q)
          ST_IDLE: begin
            if (start) begin
              if (restart_i) begin
                count_q <= '0;
                cand_q  <= (VALUE_BITS + 1)'(FirstCandidate);
              end
              if (reached) begin
                valid_o       <= 1'b1;
                prime_value_o <= '0;
                prime_index_o <= '0;
                done_res_o    <= 1'b1;
              end else begin
                state_q <= ST_NEXT;
              end
            end
          end
          ST_NEXT: begin
            if (cand_q[VALUE_BITS]) begin
              valid_o       <= 1'b1;
              prime_value_o <= '0;
              prime_index_o <= '0;
              done_res_o    <= 1'b1;
              state_q       <= ST_IDLE;
            end else begin
              c_q     <= cand_q[VALUE_BITS-1:0];
              cand_q  <= cand_q + (VALUE_BITS + 1)'(1);
              idx_q   <= '0;
              state_q <= ST_CHECK;
            end
          end
          ST_CHECK: state_q <= ST_LOAD;
          ST_LOAD: begin
            p_q     <= ram_rdata;
            state_q <= ST_DIV;
          end
          ST_DIV: begin
            if (div_done) begin
              if (div_rem == '0) begin
                state_q <= ST_NEXT;
              end else begin
                idx_q   <= idx_q + CntBits'(1);
                state_q <= ST_CHECK;
              end
            end
          end
          default: state_q <= ST_IDLE;
        endcase
      end
    end
  end

  assign busy = state_q != ST_IDLE;

`ifndef NO_ASSERTIONS
  a_result_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while still working");
  a_done_result_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && done_res_o) |-> (prime_value_o == '0 && prime_index_o == '0))
    else $error("done result carries a value");
  a_count_within_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpBits'(count_q) <= MaxPrimesC)
    else $error("prime count beyond table depth");
  a_prime_not_below_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found |-> c_q >= VALUE_BITS'(FirstCandidate))
    else $error("prime found below two");
`endif

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the trial division prime generator top level.
module testbench
  import tdpg_pkg::*;
();

  localparam int MaxPrimes    = 1024;
  localparam int ValueBits    = 16;
  localparam int ValueMax     = (1 << ValueBits) - 1;
  localparam int IdleLimit    = 50000;
  localparam int SettleCycles = 64;

  typedef struct packed {
    logic [PrimeOutBits-1:0] value;
    logic [IndexOutBits-1:0] index;
    logic                    done;
  } prime_result_t;

  class prime_sequence_tracker;
    logic [ValueBits-1:0]  prime_table [MaxPrimes];
    int unsigned           found_count;
    int unsigned           candidate;
    logic [TargetBits-1:0] target_count;
    prime_result_t         awaited_primes [$];
    int                    mismatches;

    function new();
      found_count  = 0;
      candidate    = FirstCandidate;
      target_count = TargetReset;
      mismatches   = 0;
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function bit has_divisor(int unsigned num);
      longint unsigned p;
      for (int unsigned i = 0; i < found_count && i < MaxPrimes; i++) begin
        p = prime_table[i];
        if (p == 0 || p * p > num) return 1'b0;
        if (num % p == 0) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_request(bit restart);
      int unsigned   limit;
      int unsigned   num;
      prime_result_t res;
      limit = (target_count > MaxPrimes) ? MaxPrimes : target_count;
      if (restart) begin
        found_count = 0;
        candidate   = FirstCandidate;
      end
      res.value = '0;
      res.index = '0;
      res.done  = 1'b1;
      if (found_count < limit) begin
        while (candidate <= ValueMax) begin
          num = candidate;
          candidate++;
          if (!has_divisor(num)) begin
            prime_table[found_count] = num[ValueBits-1:0];
            res.value = num[PrimeOutBits-1:0];
            res.index = found_count[IndexOutBits-1:0];
            res.done  = 1'b0;
            found_count++;
            break;
          end
        end
      end
      awaited_primes.push_back(res);
    endfunction

    task check_prime(logic [PrimeOutBits-1:0] value, logic [IndexOutBits-1:0] index,
                     logic done);
      prime_result_t want;
      if (awaited_primes.size() == 0) begin
        report($sformatf("unexpected result value %0d index %0d done %b", value, index, done));
        return;
      end
      want = awaited_primes.pop_front();
      if (value !== want.value)
        report($sformatf("prime_value %0d, want %0d", value, want.value));
      if (index !== want.index)
        report($sformatf("prime_index %0d, want %0d", index, want.index));
      if (done !== want.done)
        report($sformatf("done_res %b, want %b", done, want.done));
    endtask
  endclass

  logic                    clk_i              = 1'b0;
  logic                    rst_ni             = 1'b0;
  logic                    cfg_we_i           = 1'b0;
  logic [TargetBits-1:0]   cfg_target_count_i = '0;
  logic                    start              = 1'b0;
  logic                    restart_i          = 1'b0;
  logic                    busy;
  logic                    valid_o;
  logic [PrimeOutBits-1:0] prime_value_o;
  logic [IndexOutBits-1:0] prime_index_o;
  logic                    done_res_o;

  prime_sequence_tracker tracker = new();
  int unsigned           quiet_cycles = 0;

  trial_division_prime_generator_top #(
    .MAX_PRIMES(MaxPrimes),
    .VALUE_BITS(ValueBits)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_target_count_i(cfg_target_count_i),
    .start             (start),
    .restart_i         (restart_i),
    .busy              (busy),
    .valid_o           (valid_o),
    .prime_value_o     (prime_value_o),
    .prime_index_o     (prime_index_o),
    .done_res_o        (done_res_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) tracker.check_prime(prime_value_o, prime_index_o, done_res_o);
  end

  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || valid_o === 1'b1 || cfg_we_i) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("trial_division_prime_generator_top verification failed");
      $finish;
    end
  end

  task automatic request_prime(bit restart);
    start     <= 1'b1;
    restart_i <= restart;
    do @(posedge clk_i); while (busy !== 1'b0);
    tracker.note_request(restart);
  endtask

  task automatic sender_pause(int pct);
    if ($urandom_range(99) < pct) begin
      start     <= 1'b0;
      restart_i <= 1'($urandom_range(1));
      do @(posedge clk_i); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic run_phase(int count, int idle_pct, int restart_pct);
    repeat (count) begin
      request_prime($urandom_range(99) < restart_pct);
      sender_pause(idle_pct);
    end
  endtask

  task automatic quiesce();
    start <= 1'b0;
    do @(posedge clk_i); while (tracker.awaited_primes.size() != 0 || busy !== 1'b0);
  endtask

  task automatic set_target(logic [TargetBits-1:0] target);
    cfg_we_i           <= 1'b1;
    cfg_target_count_i <= target;
    @(posedge clk_i);
    tracker.target_count = target;
    cfg_we_i           <= 1'b0;
  endtask

  function automatic logic [TargetBits-1:0] pick_target();
    case ($urandom_range(5))
      0:       return '0;
      1:       return TargetBits'(1);
      2:       return TargetBits'($urandom_range(2, 12));
      3:       return TargetBits'($urandom_range(13, 80));
      4:       return TargetBits'(MaxPrimes);
      default: return TargetBits'($urandom_range(MaxPrimes + 1, (1 << TargetBits) - 1));
    endcase
  endfunction

  initial begin
    int idle_pcts [3] = '{0, 63, 36};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    repeat (3) request_prime(1'b0);
    request_prime(1'b1);
    repeat (2) request_prime(1'b0);
    quiesce();
    set_target(TargetBits'(3));
    repeat (2) request_prime(1'b0);
    request_prime(1'b1);
    repeat (3) request_prime(1'b0);
    quiesce();
    set_target('0);
    request_prime(1'b0);
    request_prime(1'b1);
    quiesce();
    set_target(TargetBits'(1));
    request_prime(1'b1);
    request_prime(1'b0);
    quiesce();

    for (int ph = 0; ph < 6; ph++) begin
      set_target(pick_target());
      run_phase(45, idle_pcts[ph % 3], 12);
      quiesce();
    end

    // run the full table to its capacity and past it
    set_target('1);
    request_prime(1'b1);
    run_phase(1029, 36, 0);
    quiesce();
    set_target(TargetBits'(MaxPrimes));
    request_prime(1'b0);
    request_prime(1'b1);
    run_phase(5, 63, 0);
    quiesce();

    repeat (SettleCycles) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("trial_division_prime_generator_top verification clean");
    end else begin
      $display("trial_division_prime_generator_top verification failed");
    end
    $finish;
  end

endmodule
